// ===== src/lbp_hist_pkg.sv =====
// Shared constants and types of the local binary pattern histogram block.
`timescale 1ns / 1ps
package lbp_hist_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int NUM_BINS = 256;
  localparam int MIN_SIZE = 3;

  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int PIX_W    = 8;
  localparam int CODE_W   = 8;
  localparam int CNT_W    = 20;
  localparam int ACT_W    = 2;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

  localparam logic [CFG_W-1:0] ROWS_RESET = 11'd200;
  localparam logic [CFG_W-1:0] COLS_RESET = 11'd180;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

endpackage

// ===== src/lbp_hist_if.sv =====
// Valid/ready channel interfaces for pixel requests and histogram results.
`timescale 1ns / 1ps
interface lbp_hist_in_if;
  import lbp_hist_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [PIX_W-1:0] pixel;
  logic [BIN_W-1:0] bin_index;

  modport source (output valid, action, pixel, bin_index, input ready);
  modport sink   (input valid, action, pixel, bin_index, output ready);
endinterface

interface lbp_hist_out_if;
  import lbp_hist_pkg::*;

  logic              valid;
  logic              ready;
  logic              code_valid;
  logic [CODE_W-1:0] lbp_code;
  logic [CNT_W-1:0]  bin_count;
  logic              frame_done;

  modport source (output valid, code_valid, lbp_code, bin_count, frame_done, input ready);
  modport sink   (input valid, code_valid, lbp_code, bin_count, frame_done, output ready);
endinterface

// ===== src/lbp_histogram.sv =====
// Top level: 3x3 local binary pattern coder with a 256-bin saturating histogram.
// A request passes through stage one and stage two before its result enters the output register.
// Throughput: one request per cycle; a new request is taken while a result waits, as long
// as one of the two stages behind the output register is free. The rate holds because the
// bin updated by the request just ahead is forwarded into the histogram read-modify-write.
// Reset (synchronous, rst_n low) clears position, window, pipeline and all histogram bins
// at once through per-bin valid bits; no clearing pass is needed. Line memory is not reset.
`timescale 1ns / 1ps
module lbp_histogram (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lbp_hist_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbp_hist_pkg::CFG_W-1:0] cfg_data,
  lbp_hist_in_if.sink                    in_ch,
  lbp_hist_out_if.source                 out_ch
);
  import lbp_hist_pkg::*;

  // Converts a written frame size into the index of the last row or column,
  // after clamping it to the supported range.
  function automatic int last_index(input logic [CFG_W-1:0] v, input int max_v);
    int c;
    c = int'(v);
    if (c < MIN_SIZE) begin
      c = MIN_SIZE;
    end else if (c > max_v) begin
      c = max_v;
    end
    return c - 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration and raster position (request stage).
  // The frame size is kept as the index of the last row and column so that
  // the end-of-line test is a plain equality.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic [ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [COL_W-1:0] col_pos_r, col_pos_nxt;

  // Pipeline flow control. Each stage moves when the one after it is empty
  // or moving, so bubbles are squeezed out and a stalled result does not
  // stop requests as long as there is room behind it.
  logic out_valid_r;
  logic s1_v_r, s2_v_r;
  logic out_free, s2_go, s2_free, s1_go, s1_free;
  logic in_acc;
  action_t in_act;
  logic push_acc, clear_acc;
  logic at_last_col, at_last_row, interior;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s2_go    = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;

  assign in_ch.ready = s1_free;
  assign in_acc      = in_ch.valid && s1_free;
  assign in_act      = action_t'(in_ch.action);
  assign push_acc    = in_acc && (in_act == ACT_PUSH);
  assign clear_acc   = in_acc && (in_act == ACT_CLEAR);

  assign at_last_col = (col_pos_r == last_col_r);
  assign at_last_row = (row_pos_r == last_row_r);
  // A push completes the neighborhood of the pixel up and to the left once
  // two full rows and two columns of the current row have been seen.
  assign interior    = (row_pos_r >= ROW_W'(2)) && (col_pos_r >= COL_W'(2));

  always_comb begin
    last_row_nxt = last_row_r;
    last_col_nxt = last_col_r;
    row_pos_nxt  = row_pos_r;
    col_pos_nxt  = col_pos_r;
    if (cfg_we) begin
      // Any register write, valid index or not, must be made while idle; the
      // block does not enforce this. A write to a known register also restarts the frame.
      case (cfg_index)
        REG_FRAME_ROWS: begin
          last_row_nxt = ROW_W'(last_index(cfg_data, MAX_ROWS));
          row_pos_nxt  = '0;
          col_pos_nxt  = '0;
        end
        REG_FRAME_COLS: begin
          last_col_nxt = COL_W'(last_index(cfg_data, MAX_COLS));
          row_pos_nxt  = '0;
          col_pos_nxt  = '0;
        end
        default: begin
        end
      endcase
    end else if (push_acc) begin
      if (at_last_col) begin
        col_pos_nxt = '0;
        row_pos_nxt = at_last_row ? '0 : row_pos_r + 1'b1;
      end else begin
        col_pos_nxt = col_pos_r + 1'b1;
      end
    end else if (clear_acc) begin
      row_pos_nxt = '0;
      col_pos_nxt = '0;
    end
  end

  // Restart of the window: a register write restarts it at once (the user must keep
  // the block idle then, unenforced), a clear request restarts it when it passes stage one.
  logic cfg_restart;
  assign cfg_restart = cfg_we &&
                       (cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= ROW_W'(last_index(ROWS_RESET, MAX_ROWS));
      last_col_r <= COL_W'(last_index(COLS_RESET, MAX_COLS));
      row_pos_r  <= '0;
      col_pos_r  <= '0;
    end else begin
      last_row_r <= last_row_nxt;
      last_col_r <= last_col_nxt;
      row_pos_r  <= row_pos_nxt;
      col_pos_r  <= col_pos_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: one entry per column holds the pixel two rows up (upper
  // byte) and one row up (lower byte). A push reads its column when it is
  // taken and writes back {one row up, new pixel} in stage one. Consecutive
  // pushes always address different columns (frames are at least three
  // columns wide, and a restart needs a clear request or an idle block in
  // between), so the read never meets the pending write to the same entry.
  // ---------------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_COLS];
  logic [2*PIX_W-1:0] line_rd_r;

  // Stage one registers.
  action_t          s1_act_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [BIN_W-1:0] s1_bin_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_code_v_r;
  logic             s1_done_r;

  always_ff @(posedge clk) begin
    if (push_acc) begin
      line_rd_r <= line_mem[col_pos_r];
    end
    if (s1_go && s1_act_r == ACT_PUSH) begin
      line_mem[s1_col_r] <= {line_rd_r[PIX_W-1:0], s1_pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_ch.valid;
    end
    if (in_acc) begin
      s1_act_r    <= in_act;
      s1_pix_r    <= in_ch.pixel;
      s1_bin_r    <= in_ch.bin_index;
      s1_col_r    <= col_pos_r;
      s1_code_v_r <= (in_act == ACT_PUSH) && interior;
      s1_done_r   <= (in_act == ACT_PUSH) && at_last_col && at_last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Window and pattern (stage one). Only the two newest window columns are
  // kept; the oldest column shifts out on each push. Row 0 is two rows up,
  // row 2 the current row.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] win_mid_r [3];
  logic [PIX_W-1:0] win_new_r [3];
  logic [PIX_W-1:0] top_px, mid_px, ctr_px;
  logic [CODE_W-1:0] pattern;
  logic [BIN_W-1:0]  hist_raddr;

  assign top_px = line_rd_r[2*PIX_W-1:PIX_W];
  assign mid_px = line_rd_r[PIX_W-1:0];
  assign ctr_px = win_new_r[1];

  // Each neighbor brighter than the center sets its bit, going from the
  // left neighbor counterclockwise around to the upper-left one.
  always_comb begin
    pattern    = '0;
    pattern[0] = win_mid_r[1] > ctr_px;
    pattern[1] = win_mid_r[2] > ctr_px;
    pattern[2] = win_new_r[2] > ctr_px;
    pattern[3] = s1_pix_r     > ctr_px;
    pattern[4] = mid_px       > ctr_px;
    pattern[5] = top_px       > ctr_px;
    pattern[6] = win_new_r[0] > ctr_px;
    pattern[7] = win_mid_r[0] > ctr_px;
  end

  assign hist_raddr = (s1_act_r == ACT_PUSH) ? BIN_W'(pattern) : s1_bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart || (s1_go && s1_act_r == ACT_CLEAR)) begin
      for (int i = 0; i < 3; i++) begin
        win_mid_r[i] <= '0;
        win_new_r[i] <= '0;
      end
    end else if (s1_go && s1_act_r == ACT_PUSH) begin
      for (int i = 0; i < 3; i++) begin
        win_mid_r[i] <= win_new_r[i];
      end
      win_new_r[0] <= top_px;
      win_new_r[1] <= mid_px;
      win_new_r[2] <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Histogram (stage two). The bin is read when the request enters stage two
  // and written back when it leaves. A bin written by the request just ahead
  // was read before that write landed, so the last write is kept and
  // forwarded. Per-bin valid bits give the all-zero state after reset or a
  // clear without touching the memory.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]    hist_mem [NUM_BINS];
  logic [CNT_W-1:0]    hist_rd_r;
  logic [NUM_BINS-1:0] hist_vld_r;
  logic [BIN_W-1:0]    wr_addr_r;
  logic [CNT_W-1:0]    wr_data_r;
  logic                wr_vld_r;

  action_t           s2_act_r;
  logic [BIN_W-1:0]  s2_addr_r;
  logic              s2_code_v_r;
  logic              s2_done_r;

  logic [CNT_W-1:0]  cur_count, new_count;
  logic              s2_update, s2_clear;

  always_comb begin
    if (wr_vld_r && wr_addr_r == s2_addr_r) begin
      cur_count = wr_data_r;
    end else if (hist_vld_r[s2_addr_r]) begin
      cur_count = hist_rd_r;
    end else begin
      cur_count = '0;
    end
  end

  // Counts saturate at all ones.
  assign new_count = (&cur_count) ? cur_count : cur_count + 1'b1;
  assign s2_update = s2_go && s2_act_r == ACT_PUSH && s2_code_v_r;
  assign s2_clear  = s2_go && s2_act_r == ACT_CLEAR;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      hist_rd_r <= hist_mem[hist_raddr];
    end
    if (s2_update) begin
      hist_mem[s2_addr_r] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || s2_clear) begin
      hist_vld_r <= '0;
      wr_vld_r   <= 1'b0;
    end else if (s2_update) begin
      hist_vld_r[s2_addr_r] <= 1'b1;
      wr_vld_r              <= 1'b1;
    end
    if (s2_update) begin
      wr_addr_r <= s2_addr_r;
      wr_data_r <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
    if (s1_go) begin
      s2_act_r    <= s1_act_r;
      s2_addr_r   <= hist_raddr;
      s2_code_v_r <= s1_code_v_r;
      s2_done_r   <= s1_done_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. Every request gives exactly one result; fields that do
  // not apply to the request are zero.
  // ---------------------------------------------------------------------------
  logic              out_code_v_r;
  logic [CODE_W-1:0] out_code_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_v_r;
    end
    if (s2_go) begin
      out_code_v_r <= s2_code_v_r;
      out_code_r   <= s2_code_v_r ? CODE_W'(s2_addr_r) : '0;
      out_count_r  <= (s2_act_r == ACT_READ) ? cur_count : '0;
      out_done_r   <= s2_done_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_valid = out_code_v_r;
  assign out_ch.lbp_code   = out_code_r;
  assign out_ch.bin_count  = out_count_r;
  assign out_ch.frame_done = out_done_r;

`ifndef SYNTHESIS
  // The last pixel of a frame always completes an interior center.
  a_done_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_code_v_r)
    else $error("frame end without a pattern code");

  // The raster position never runs past the configured frame.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    col_pos_r <= last_col_r && row_pos_r <= last_row_r)
    else $error("raster position outside the frame");

  // A line memory read never hits the column being written back.
  a_line_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    push_acc && s1_go && s1_act_r == ACT_PUSH |-> col_pos_r != s1_col_r)
    else $error("line memory read and write to the same column");

  // A histogram update leaves its bin valid and forwardable.
  a_hist_update: assert property (@(posedge clk) disable iff (!rst_n)
    s2_update |=> hist_vld_r[wr_addr_r] && wr_vld_r && wr_addr_r == $past(s2_addr_r))
    else $error("histogram update not recorded");
`endif

endmodule
